/* sv/rrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrm_pkg
// Shared widths, codes and constants of the ring rate model Euler step.
// ----------------------------------------------------------------------------
package rrm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 7;
  localparam int IDX_W     = 2;
  localparam int STEP_W    = 31;
  localparam int ACC_W     = 56;

  typedef enum logic [1:0] {
    MODE_LOAD_POP  = 2'd0,
    MODE_LOAD_KERN = 2'd1,
    MODE_STEP      = 2'd2
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TIME_STEP    = 2'd0,
    REG_DRIVE_MEAN   = 2'd1,
    REG_DRIVE_SPREAD = 2'd2,
    REG_POPS_USED    = 2'd3
  } reg_idx_t;

  localparam logic [STEP_W-1:0] TIME_STEP_RST    = 31'd655;
  localparam logic [STEP_W-1:0] DRIVE_SPREAD_RST = 31'd65536;
  localparam logic [CNT_W-1:0]  POPS_USED_RST    = 7'd64;

  localparam logic [63:0] PI_SQ_Q28  = 64'd2649351758;
  localparam logic [31:0] PI_SQ      =
    32'((PI_SQ_Q28 + (64'd1 << (27 - FRAC_BITS))) >> (28 - FRAC_BITS));
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  dividend;
    logic [CNT_W-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [ACC_W-1:0]  quotient;
  } div_rsp_t;

endpackage

/* sv/rrm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrm_item_if / rrm_result_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface rrm_item_if
  import rrm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  mode_t                    mode;
  logic [SLOT_W-1:0]        slot;
  logic signed [DATA_W-1:0] rate_in;
  logic signed [DATA_W-1:0] potential_in;
  logic signed [DATA_W-1:0] kernel_in;

  modport source (output valid, mode, slot, rate_in, potential_in, kernel_in,
                  input ready);
  modport sink   (input valid, mode, slot, rate_in, potential_in, kernel_in,
                  output ready);
endinterface

interface rrm_result_if
  import rrm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [SLOT_W-1:0]        population;
  logic signed [DATA_W-1:0] rate_out;
  logic signed [DATA_W-1:0] potential_out;
  logic signed [DATA_W-1:0] coupling_out;
  logic                     saturated;
  logic                     last;

  modport source (output valid, population, rate_out, potential_out, coupling_out,
                  saturated, last, input ready);
  modport sink   (input valid, population, rate_out, potential_out, coupling_out,
                  saturated, last, output ready);
endinterface

/* sv/rrm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrm_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rrm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrm_div
// Serial signed divider, four quotient bits per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module rrm_div
  import rrm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int RADIX = 4;
  localparam int ITER  = ACC_W / RADIX;
  localparam int IW    = $clog2(ITER + 1);

  logic              busy;
  logic              done;
  logic              neg;
  logic [ACC_W-1:0]  mag;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  dvs;
  logic [IW-1:0]     cnt;
  logic [ACC_W-1:0]  mag_next;
  logic [CNT_W:0]    rem_next;

  always_comb begin
    mag_next = mag;
    rem_next = rem;
    for (int k = 0; k < RADIX; k++) begin
      rem_next = {rem_next[CNT_W-1:0], mag_next[ACC_W-1]};
      mag_next = {mag_next[ACC_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dvs}) begin
        rem_next    = rem_next - {1'b0, dvs};
        mag_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      neg  <= req.dividend[ACC_W-1];
      mag  <= req.dividend[ACC_W-1] ? ACC_W'(-req.dividend) : ACC_W'(req.dividend);
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      mag <= mag_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
      if (cnt == IW'(ITER - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = neg ? -$signed(mag) : $signed(mag);

endmodule

/* sv/ring_rate_model_euler_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_rate_model_euler_step
// Forward Euler step of a ring of rate populations, state kept in RAM.
// ----------------------------------------------------------------------------
// Load words (population state or kernel entry) are accepted only while no
// step runs. For each population of a step the coupling sum runs one
// multiply-accumulate per cycle through the single shared 33x33 multiplier,
// reading rate and kernel RAMs, then a serial divider normalizes it while
// the same multiplier works the update terms; a final pass copies the new
// state from the scratch RAM back into the state RAMs. Results leave
// through an output register; a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module ring_rate_model_euler_step
  import rrm_pkg::*;
#(
  parameter int MAX_POPULATIONS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_index,
  input  logic [DATA_W-1:0]   wr_data,
  rrm_item_if.sink            item,
  rrm_result_if.source        result
);

  localparam int AW     = (MAX_POPULATIONS > 1) ? $clog2(MAX_POPULATIONS) : 1;
  localparam int NW     = AW + 1;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int SUM_W  = 68;
  localparam int PW     = 48;

  localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF32 = PROD_W'(1) << 31;
  localparam logic signed [SUM_W-1:0]  S32MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0]  S32MIN = ~S32MAX;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  typedef enum logic [4:0] {
    IDLE, PREP, PREP2, ACC, R_RV, P1, P2, P3, P4, P5, P6,
    WDIV, DV, P7, P8, EMIT, COPY
  } state_t;

  function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    return (p + HALF) >>> FRAC_BITS;
  endfunction

  function automatic sat_t sat(input logic signed [SUM_W-1:0] v);
    sat_t s;
    s.clip = 1'b0;
    s.val  = DATA_W'(v);
    if (v > S32MAX) begin
      s.clip = 1'b1;
      s.val  = DATA_W'(S32MAX);
    end else if (v < S32MIN) begin
      s.clip = 1'b1;
      s.val  = DATA_W'(S32MIN);
    end
    return s;
  endfunction

  // configuration
  logic [STEP_W-1:0]        time_step;
  logic signed [DATA_W-1:0] drive_mean;
  logic [STEP_W-1:0]        drive_spread;
  logic [CNT_W-1:0]         pops_used;
  logic [NW-1:0]            n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= TIME_STEP_RST;
      drive_mean   <= '0;
      drive_spread <= DRIVE_SPREAD_RST;
      pops_used    <= POPS_USED_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_TIME_STEP:    time_step    <= wr_data[STEP_W-1:0];
        REG_DRIVE_MEAN:   drive_mean   <= wr_data;
        REG_DRIVE_SPREAD: drive_spread <= wr_data[STEP_W-1:0];
        REG_POPS_USED:    pops_used    <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pops_used == '0) begin
      n_eff = NW'(1);
    end else if ({1'b0, pops_used} > 8'(MAX_POPULATIONS)) begin
      n_eff = NW'(MAX_POPULATIONS);
    end else begin
      n_eff = NW'(pops_used);
    end
  end

  // sequencer state
  state_t                    state;
  logic [NW-1:0]             x;
  logic [NW-1:0]             i;
  logic [NW-1:0]             j;
  logic [AW-1:0]             cj;
  logic                      v1;
  logic                      v2;
  logic                      cv;
  logic                      clip;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DATA_W-1:0]  spread_term;
  logic signed [DATA_W-1:0]  r;
  logic signed [DATA_W-1:0]  v;
  logic signed [DATA_W-1:0]  dr;
  logic signed [DATA_W-1:0]  rr;
  logic signed [DATA_W-1:0]  dv;
  logic signed [DATA_W-1:0]  s;
  logic signed [DATA_W-1:0]  nr;
  logic signed [DATA_W-1:0]  nv;
  logic signed [PW-1:0]      vv;
  logic signed [PW-1:0]      prr;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_rnd;

  // memories
  logic              rate_we;
  logic [AW-1:0]     rate_waddr;
  logic [DATA_W-1:0] rate_wdata;
  logic [AW-1:0]     rate_raddr;
  logic [DATA_W-1:0] rate_rdata;
  logic              pot_we;
  logic [DATA_W-1:0] pot_wdata;
  logic [DATA_W-1:0] pot_rdata;
  logic              kern_we;
  logic [AW-1:0]     kern_raddr;
  logic [DATA_W-1:0] kern_rdata;
  logic              scr_we;
  logic [2*DATA_W-1:0] scr_rdata;

  logic     item_acc;
  logic     slot_ok;
  logic     acc_issue;
  logic     acc_done;
  logic [NW-1:0] ring_dist;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign item.ready = (state == IDLE);
  assign item_acc   = item.valid && item.ready;
  assign slot_ok    = ({1'b0, item.slot} < 7'(MAX_POPULATIONS));
  assign acc_issue  = (state == ACC) && (i < n_eff);
  assign acc_done   = (state == ACC) && !acc_issue && !v1 && !v2;
  assign ring_dist  = (i >= x) ? (i - x) : (x - i);

  assign rate_we    = (item_acc && item.mode == MODE_LOAD_POP && slot_ok) ||
                      (state == COPY && cv);
  assign pot_we     = rate_we;
  assign rate_waddr = (state == COPY) ? cj : item.slot[AW-1:0];
  assign rate_wdata = (state == COPY) ? scr_rdata[2*DATA_W-1:DATA_W] : item.rate_in;
  assign pot_wdata  = (state == COPY) ? scr_rdata[DATA_W-1:0] : item.potential_in;
  assign kern_we    = item_acc && item.mode == MODE_LOAD_KERN && slot_ok;
  assign rate_raddr = acc_issue ? i[AW-1:0] : x[AW-1:0];
  assign kern_raddr = ring_dist[AW-1:0];
  assign scr_we     = (state == EMIT) && (!result.valid || result.ready);

  assign div_req.start    = acc_done;
  assign div_req.dividend = acc;
  assign div_req.divisor  = CNT_W'(n_eff);

  rrm_ram #(.W(DATA_W), .DEPTH(MAX_POPULATIONS)) u_rate (
    .clk(clk), .we(rate_we), .waddr(rate_waddr), .wdata(rate_wdata),
    .raddr(rate_raddr), .rdata(rate_rdata)
  );

  rrm_ram #(.W(DATA_W), .DEPTH(MAX_POPULATIONS)) u_pot (
    .clk(clk), .we(pot_we), .waddr(rate_waddr), .wdata(pot_wdata),
    .raddr(x[AW-1:0]), .rdata(pot_rdata)
  );

  rrm_ram #(.W(DATA_W), .DEPTH(MAX_POPULATIONS)) u_kern (
    .clk(clk), .we(kern_we), .waddr(item.slot[AW-1:0]), .wdata(item.kernel_in),
    .raddr(kern_raddr), .rdata(kern_rdata)
  );

  rrm_ram #(.W(2*DATA_W), .DEPTH(MAX_POPULATIONS)) u_scr (
    .clk(clk), .we(scr_we), .waddr(x[AW-1:0]), .wdata({nr, nv}),
    .raddr(j[AW-1:0]), .rdata(scr_rdata)
  );

  rrm_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      PREP: begin
        mul_a = MUL_W'({2'b0, drive_spread});
        mul_b = MUL_W'({2'b0, INV_PI_Q32});
      end
      ACC: begin
        mul_a = MUL_W'($signed(kern_rdata));
        mul_b = MUL_W'($signed(rate_rdata));
      end
      P1: begin
        mul_a = MUL_W'(v);
        mul_b = MUL_W'(r);
      end
      P2: begin
        mul_a = MUL_W'(r);
        mul_b = MUL_W'(r);
      end
      P3: begin
        mul_a = MUL_W'(v);
        mul_b = MUL_W'(v);
      end
      P4: begin
        mul_a = MUL_W'({2'b0, time_step});
        mul_b = MUL_W'(dr);
      end
      P5: begin
        mul_a = MUL_W'({1'b0, PI_SQ});
        mul_b = MUL_W'(rr);
      end
      P7: begin
        mul_a = MUL_W'({2'b0, time_step});
        mul_b = MUL_W'(dv);
      end
      default: ;
    endcase
  end

  assign prod_rnd = rnd(prod);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    sat_t t;
    if (rst) begin
      state        <= IDLE;
      result.valid <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      cv           <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != EMIT) begin
        result.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (item_acc && item.mode == MODE_STEP) begin
            x     <= '0;
            state <= PREP;
          end
        end
        PREP: begin
          state <= PREP2;
        end
        PREP2: begin
          spread_term <= DATA_W'((prod + HALF32) >>> 32);
          i     <= '0;
          acc   <= '0;
          clip  <= 1'b0;
          v1    <= 1'b0;
          v2    <= 1'b0;
          state <= ACC;
        end
        ACC: begin
          if (acc_issue) begin
            i <= i + 1'b1;
          end
          v1 <= acc_issue;
          v2 <= v1;
          if (v2) begin
            acc <= acc + ACC_W'(prod_rnd);
          end
          if (acc_done) begin
            state <= R_RV;
          end
        end
        R_RV: begin
          r     <= rate_rdata;
          v     <= pot_rdata;
          state <= P1;
        end
        P1: begin
          state <= P2;
        end
        P2: begin
          t     = sat(SUM_W'(spread_term) + (SUM_W'(prod_rnd) <<< 1));
          dr    <= t.val;
          clip  <= clip | t.clip;
          state <= P3;
        end
        P3: begin
          t     = sat(SUM_W'(prod_rnd));
          rr    <= t.val;
          clip  <= clip | t.clip;
          state <= P4;
        end
        P4: begin
          vv    <= PW'(prod_rnd);
          state <= P5;
        end
        P5: begin
          t     = sat(SUM_W'(r) + SUM_W'(prod_rnd));
          nr    <= t.val;
          clip  <= clip | t.clip;
          state <= P6;
        end
        P6: begin
          prr   <= PW'(prod_rnd);
          state <= WDIV;
        end
        WDIV: begin
          if (div_rsp.done) begin
            t     = sat(SUM_W'(div_rsp.quotient));
            s     <= t.val;
            clip  <= clip | t.clip;
            state <= DV;
          end
        end
        DV: begin
          t     = sat(SUM_W'(drive_mean) + SUM_W'(vv) - SUM_W'(prr) + SUM_W'(s));
          dv    <= t.val;
          clip  <= clip | t.clip;
          state <= P7;
        end
        P7: begin
          state <= P8;
        end
        P8: begin
          t     = sat(SUM_W'(v) + SUM_W'(prod_rnd));
          nv    <= t.val;
          clip  <= clip | t.clip;
          state <= EMIT;
        end
        EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.population    <= SLOT_W'(x);
            result.rate_out      <= nr;
            result.potential_out <= nv;
            result.coupling_out  <= s;
            result.saturated     <= clip;
            result.last          <= (x == n_eff - 1'b1);
            if (x == n_eff - 1'b1) begin
              j     <= '0;
              cv    <= 1'b0;
              state <= COPY;
            end else begin
              x     <= x + 1'b1;
              i     <= '0;
              acc   <= '0;
              clip  <= 1'b0;
              v1    <= 1'b0;
              v2    <= 1'b0;
              state <= ACC;
            end
          end
        end
        COPY: begin
          if (j < n_eff) begin
            j <= j + 1'b1;
          end
          cv <= (j < n_eff);
          cj <= j[AW-1:0];
          if (j == n_eff && !cv) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_write_in_acc: assert property (@(posedge clk) disable iff (rst)
    (state == ACC) |-> !rate_we)
    else $error("state RAM written during coupling sum");

  a_div_done_at_emit: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> div_rsp.done)
    else $error("result emitted before coupling divide finished");

  a_copy_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == COPY && cv) |-> ({1'b0, cj} < n_eff))
    else $error("copy-back beyond populations in use");

endmodule

/* tb/tb_ring_rate_model_euler_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_rate_model_euler_step
// Self-checking bench for the ring rate model Euler step. Loads population
// state and kernel tables, advances the ring under several register
// settings and checks every result word against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_ring_rate_model_euler_step;
  import rrm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         NPOP        = 64;
  localparam longint     CYCLE_LIMIT = 5000000;
  localparam longint     Q_MAX       = 64'sd2147483647;
  localparam longint     Q_MIN       = -64'sd2147483648;

  typedef struct {
    logic [SLOT_W-1:0]        population;
    logic signed [DATA_W-1:0] rate;
    logic signed [DATA_W-1:0] potential;
    logic signed [DATA_W-1:0] coupling;
    logic                     saturated;
    logic                     last;
  } pop_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [DATA_W-1:0] wr_data = '0;

  rrm_item_if   item ();
  rrm_result_if result ();

  ring_rate_model_euler_step u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item.sink),
    .result   (result.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [DATA_W-1:0] rate_mem [NPOP];
  logic signed [DATA_W-1:0] pot_mem  [NPOP];
  logic signed [DATA_W-1:0] kern_mem [NPOP];
  longint dt_q, eta_q, spread_q;
  int     pops_cfg;

  pop_update_t pending_updates [$];
  int     failures = 0;
  int     steps_run;
  int     words_checked = 0;
  int     burst_left;
  bit     sender_idle_on;
  int     stall_pct;
  longint cycles = 0;

  function automatic longint rnd_q(longint p, int s);
    return (p + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat_q(longint v, inout bit clip);
    if (v > Q_MAX) begin
      clip = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      clip = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  task automatic advance_ring();
    int n, d;
    longint pi_sq, spread_term, acc, s, r, v, rr, dr, dv, nr, nv;
    bit clip;
    pop_update_t u;
    logic signed [DATA_W-1:0] nxt_r [NPOP];
    logic signed [DATA_W-1:0] nxt_v [NPOP];
    n = pops_cfg;
    if (n < 1) n = 1;
    if (n > NPOP) n = NPOP;
    pi_sq = rnd_q(64'sd2649351758, 28 - FRAC_BITS);
    spread_term = rnd_q(spread_q * 64'sd1367130551, 32);
    for (int x = 0; x < n; x++) begin
      clip = 1'b0;
      r = rate_mem[x];
      v = pot_mem[x];
      acc = 0;
      for (int i = 0; i < n; i++) begin
        d = (i > x) ? i - x : x - i;
        acc += rnd_q(longint'(kern_mem[d]) * longint'(rate_mem[i]), FRAC_BITS);
      end
      s  = sat_q(acc / n, clip);
      dr = sat_q(spread_term + 2 * rnd_q(v * r, FRAC_BITS), clip);
      rr = sat_q(rnd_q(r * r, FRAC_BITS), clip);
      dv = sat_q(eta_q + rnd_q(v * v, FRAC_BITS) - rnd_q(pi_sq * rr, FRAC_BITS) + s, clip);
      nr = sat_q(r + rnd_q(dt_q * dr, FRAC_BITS), clip);
      nv = sat_q(v + rnd_q(dt_q * dv, FRAC_BITS), clip);
      nxt_r[x] = nr[31:0];
      nxt_v[x] = nv[31:0];
      u.population = x[SLOT_W-1:0];
      u.rate       = nr[31:0];
      u.potential  = nv[31:0];
      u.coupling   = s[31:0];
      u.saturated  = clip;
      u.last       = (x == n - 1);
      pending_updates.push_back(u);
    end
    for (int x = 0; x < n; x++) begin
      rate_mem[x] = nxt_r[x];
      pot_mem[x]  = nxt_v[x];
    end
    steps_run++;
  endtask

  task automatic send_word(mode_t m, logic [SLOT_W-1:0] s, logic [DATA_W-1:0] r,
                           logic [DATA_W-1:0] v, logic [DATA_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (sender_idle_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 20) : 0;
      if (gap > 0) begin
        item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.valid        <= 1'b1;
    item.mode         <= m;
    item.slot         <= s;
    item.rate_in      <= r;
    item.potential_in <= v;
    item.kernel_in    <= k;
    do @(posedge clk); while (!item.ready);
    case (m)
      MODE_LOAD_POP: begin
        rate_mem[s] = r;
        pot_mem[s]  = v;
      end
      MODE_LOAD_KERN: kern_mem[s] = k;
      MODE_STEP:      advance_ring();
      default: ;
    endcase
  endtask

  // hold off until the block has delivered everything and finished copy-back
  task automatic drain();
    item.valid <= 1'b0;
    burst_left = 0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TIME_STEP:    dt_q = longint'(d[30:0]);
      REG_DRIVE_MEAN:   eta_q = longint'($signed(d));
      REG_DRIVE_SPREAD: spread_q = longint'(d[30:0]);
      REG_POPS_USED:    pops_cfg = int'(d[6:0]);
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] rand_q(int span);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return DATA_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic step_ring();
    send_word(MODE_STEP, SLOT_W'($urandom()), $urandom(), $urandom(), $urandom());
  endtask

  task automatic load_ring(int count, int span);
    for (int p = 0; p < count; p++) begin
      send_word(MODE_LOAD_POP, SLOT_W'(p), rand_q(span), rand_q(span), $urandom());
      send_word(MODE_LOAD_KERN, SLOT_W'(p), $urandom(), $urandom(), rand_q(span));
    end
  endtask

  task automatic test_reset_settings();
    load_ring(NPOP, 65536);
    step_ring();
  endtask

  task automatic test_field_extremes();
    drain();
    write_reg(REG_POPS_USED, 32'd2);
    send_word(MODE_LOAD_POP, 6'd0, 32'h7fffffff, 32'h80000000, 32'h0);
    send_word(MODE_LOAD_POP, 6'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_word(MODE_LOAD_KERN, 6'd0, 32'hffffffff, 32'h0, 32'h7fffffff);
    send_word(MODE_LOAD_KERN, 6'd1, 32'h0, 32'hffffffff, 32'h80000000);
    send_word(mode_t'(MODE_UNUSED), 6'd63, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    step_ring();
    send_word(MODE_LOAD_POP, 6'd63, 32'h0, 32'h0, 32'h0);
    send_word(MODE_LOAD_KERN, 6'd63, 32'h0, 32'h0, 32'h0);
    step_ring();
  endtask

  task automatic test_register_extremes();
    drain();
    write_reg(REG_TIME_STEP, 32'h7fffffff);
    write_reg(REG_DRIVE_MEAN, 32'h7fffffff);
    write_reg(REG_DRIVE_SPREAD, 32'h7fffffff);
    write_reg(REG_POPS_USED, 32'd0);
    step_ring();
    drain();
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_DRIVE_MEAN, 32'h80000000);
    write_reg(REG_DRIVE_SPREAD, 32'd0);
    write_reg(REG_POPS_USED, 32'd127);
    step_ring();
    drain();
    write_reg(REG_TIME_STEP, 32'hffffffff);
    write_reg(REG_POPS_USED, 32'd1);
    step_ring();
    drain();
    write_reg(REG_TIME_STEP, 32'd655);
    write_reg(REG_DRIVE_MEAN, 32'd0);
    write_reg(REG_DRIVE_SPREAD, 32'd65536);
    write_reg(REG_POPS_USED, 32'd64);
    step_ring();
  endtask

  task automatic test_random_traffic(int count, int max_pops);
    int pick;
    drain();
    write_reg(REG_TIME_STEP, $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 3000));
    write_reg(REG_DRIVE_MEAN, rand_q(4 * 65536));
    write_reg(REG_DRIVE_SPREAD, $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 200000));
    write_reg(REG_POPS_USED, $urandom_range(1, max_pops));
    sender_idle_on = $urandom_range(0, 3) != 0;
    stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 70);
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        step_ring();
      else if (pick < 7)
        send_word(MODE_LOAD_POP, SLOT_W'($urandom()), rand_q(2 * 65536),
                  rand_q(2 * 65536), $urandom());
      else if (pick < 9)
        send_word(MODE_LOAD_KERN, SLOT_W'($urandom()), $urandom(), $urandom(),
                  rand_q(2 * 65536));
      else
        send_word(mode_t'(MODE_UNUSED), SLOT_W'($urandom()), $urandom(), $urandom(),
                  $urandom());
      if (j == count / 2) drain();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    pop_update_t w;
    if (!rst && result.valid && result.ready) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected result word for population %0d", result.population);
        failures++;
      end else begin
        w = pending_updates.pop_front();
        words_checked++;
        if (result.population !== w.population) begin
          $error("population: expected %0d got %0d", w.population, result.population);
          failures++;
        end
        if (result.rate_out !== w.rate) begin
          $error("rate_out: expected %0d got %0d", w.rate, result.rate_out);
          failures++;
        end
        if (result.potential_out !== w.potential) begin
          $error("potential_out: expected %0d got %0d", w.potential, result.potential_out);
          failures++;
        end
        if (result.coupling_out !== w.coupling) begin
          $error("coupling_out: expected %0d got %0d", w.coupling, result.coupling_out);
          failures++;
        end
        if (result.saturated !== w.saturated) begin
          $error("saturated: expected %0d got %0d", w.saturated, result.saturated);
          failures++;
        end
        if (result.last !== w.last) begin
          $error("last: expected %0d got %0d", w.last, result.last);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    result.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ring_rate_model_euler_step] ERROR");
      $finish;
    end
  end

  initial begin
    steps_run = 0;
    burst_left = 0;
    sender_idle_on = 1'b1;
    stall_pct = 30;
    dt_q = 655;
    eta_q = 0;
    spread_q = 65536;
    pops_cfg = 64;
    item.valid        <= 1'b0;
    item.mode         <= MODE_LOAD_POP;
    item.slot         <= '0;
    item.rate_in      <= '0;
    item.potential_in <= '0;
    item.kernel_in    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_field_extremes();
    test_register_extremes();
    for (int ph = 0; ph < 2; ph++) test_random_traffic(6, ph == 1 ? 64 : 8);
    drain();
    $display("covered %0d steps and %0d checked result words", steps_run, words_checked);
    $display("register extremes, unused mode, clipping and random stalls exercised");
    if (failures == 0)
      $display("[ring_rate_model_euler_step] OK");
    else
      $display("[ring_rate_model_euler_step] ERROR");
    $finish;
  end

endmodule
